/* rtl/mmp_pkg.sv */
// shared types and constants of the mixture posterior block
// no dependencies
`default_nettype none
package mmp_pkg;

  typedef enum logic [1:0] {
    OP_WRITE_PRIOR    = 2'd0,
    OP_WRITE_CATEGORY = 2'd1,
    OP_SAMPLE         = 2'd2,
    OP_NONE           = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_MUL_RD,
    ST_MUL_EX,
    ST_MUL_WR,
    ST_NORM_FIND,
    ST_NORM_RD,
    ST_NORM_WR,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_DIV_RD,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DIV_OUT
  } st_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam logic [31:0] Q_ONE            = 32'h8000_0000;
  localparam logic [11:0] EXP_MAX          = 12'd4095;
  localparam logic        REG_CLUSTER_COUNT = 1'b0;
  localparam int          SUM_W            = 36;
  localparam int          RESULT_LIMIT     = 16;

endpackage
`default_nettype wire

/* rtl/mmp_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module mmp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/mmp_divider.sv */
// iterative restoring divider, one quotient bit per cycle: (p << 31) / sum
// depends on mmp_pkg
`default_nettype none
module mmp_divider import mmp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [31:0]      dividend,
  input  wire logic [SUM_W-1:0] divisor,
  output div_stat_t             stat,
  output logic      [31:0]      quotient
);
  logic             busy_r, done_r, low_r;
  logic [4:0]       cnt_r;
  logic [SUM_W-1:0] rem_r, div_r, rem_nxt;
  logic [31:0]      q_r;
  logic [SUM_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_r, (cnt_r == 5'd31) ? low_r : 1'b0};
    ge      = rem_sh >= {1'b0, div_r};
    rem_nxt = ge ? SUM_W'(rem_sh - {1'b0, div_r}) : rem_sh[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && cnt_r == 5'd0) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= 5'd31;
      rem_r <= SUM_W'(dividend >> 1);
      low_r <= dividend[0];
      div_r <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 5'd1;
      rem_r <= rem_nxt;
      q_r   <= {q_r[30:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;
endmodule
`default_nettype wire

/* rtl/multinomial_mixture_posterior.sv */
// top level of the mixture of multinomials posterior (e step) block
// depends on mmp_pkg, mmp_ram and mmp_divider
`default_nettype none
// Table writes (prior or category entry) are taken in idle and the block stays
// ready. A sample feature runs a sequencer over one shared 32x32 multiplier:
// read, multiply and write back for each cluster in use, then a one bit a
// cycle leading-zero search and, when it shifts, a read and a write per
// cluster for the renormalization. The first feature of a sample first copies
// all MAX_CLUSTERS priors into the product memory, a read and a write each.
// The feature marked last adds a sum pass over the clusters in use and then
// one 32 step restoring division per cluster, which also waits for
// the result register to be free. Posteriors leave in cluster order through a
// one-entry output register; the next request is taken as soon as the
// sequencer is back in idle. cluster_count sits at byte address 0 of the
// configuration port.
module multinomial_mixture_posterior import mmp_pkg::*; #(
  parameter int MAX_CLUSTERS   = 16,
  parameter int MAX_FEATURES   = 64,
  parameter int MAX_CATEGORIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [3:0]  in_cluster_index,
  input  wire logic [5:0]  in_feature_index,
  input  wire logic [3:0]  in_category,
  input  wire logic [31:0] in_table_value,
  input  wire logic        in_last_feature,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [3:0]  out_cluster_id,
  output logic      [31:0] out_posterior,
  output logic             out_last_cluster
);
  localparam int IW    = $clog2(MAX_CLUSTERS);
  localparam int TD    = MAX_FEATURES * MAX_CLUSTERS * MAX_CATEGORIES;
  localparam int CAW   = $clog2(TD);
  localparam int LIM   = (MAX_CLUSTERS < RESULT_LIMIT) ? MAX_CLUSTERS : RESULT_LIMIT;
  localparam logic [4:0]  LIM5    = 5'(LIM);
  localparam logic [IW-1:0] IDX_TOP = IW'(MAX_CLUSTERS - 1);
  localparam logic [CAW-1:0] CAT_STEP = CAW'(MAX_CATEGORIES);

  // configuration register
  logic [4:0] count_r;
  logic       cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CLUSTER_COUNT);
  assign prdata = (paddr[2] == REG_CLUSTER_COUNT) ? {27'd0, count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 5'd16;
    end else if (cfg_wr) begin
      count_r <= pwdata[4:0];
    end
  end

  // clusters in use, as last index
  logic [4:0]    n_eff;
  logic [IW-1:0] n_m1;
  always_comb begin
    n_eff = count_r;
    if (count_r == 5'd0) begin
      n_eff = 5'd1;
    end else if (count_r > LIM5) begin
      n_eff = LIM5;
    end
    n_m1 = IW'(n_eff - 5'd1);
  end

  // sequencer state
  st_t            state_r, state_nxt;
  logic [IW-1:0]  idx_r, idx_nxt;
  logic           started_r, started_nxt;
  logic [11:0]    exp_r, exp_nxt;
  logic [31:0]    max_r, max_nxt;
  logic [4:0]     s_r, s_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [63:0]    mul_r;
  logic [CAW-1:0] cat_addr_r, cat_addr_nxt;
  logic           in_range_r, in_range_nxt;
  logic           last_r, last_nxt;

  // output register
  logic        ov_r, ov_nxt;
  logic [3:0]  oid_r;
  logic [31:0] opost_r;
  logic        olast_r;
  logic        out_load;

  // memories
  logic           prior_we, prod_we, cat_we;
  logic [IW-1:0]  prior_waddr, prod_waddr;
  logic [31:0]    prior_rdata, prod_rdata, prod_wdata, cat_rdata, wval;
  logic [CAW-1:0] cat_waddr;

  // divider
  logic        div_start;
  div_stat_t   div_stat;
  logic [31:0] div_q;

  logic        in_acc;
  logic        wr_ok_c, wr_ok_p, smp_ok;
  logic [32:0] prod_shift;
  logic [31:0] prod_step, factor;
  logic [12:0] exp_sum;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // saturate values above one when written
  assign wval = (in_table_value > Q_ONE) ? Q_ONE : in_table_value;

  assign wr_ok_p = int'(in_cluster_index) < MAX_CLUSTERS;
  assign smp_ok  = (int'(in_feature_index) < MAX_FEATURES) &&
                   (int'(in_category) < MAX_CATEGORIES);
  assign wr_ok_c = wr_ok_p && smp_ok;

  assign prior_we    = in_acc && (op_t'(in_operation) == OP_WRITE_PRIOR) && wr_ok_p;
  assign prior_waddr = IW'(in_cluster_index);
  assign cat_we      = in_acc && (op_t'(in_operation) == OP_WRITE_CATEGORY) && wr_ok_c;
  assign cat_waddr   = CAW'((int'(in_feature_index) * MAX_CLUSTERS + int'(in_cluster_index))
                            * MAX_CATEGORIES + int'(in_category));

  mmp_ram #(.WIDTH(32), .DEPTH(MAX_CLUSTERS)) u_prior (
    .clk(clk), .we(prior_we), .waddr(prior_waddr), .wdata(wval),
    .raddr(idx_r), .rdata(prior_rdata)
  );

  mmp_ram #(.WIDTH(32), .DEPTH(TD)) u_category (
    .clk(clk), .we(cat_we), .waddr(cat_waddr), .wdata(wval),
    .raddr(cat_addr_r), .rdata(cat_rdata)
  );

  mmp_ram #(.WIDTH(32), .DEPTH(MAX_CLUSTERS)) u_product (
    .clk(clk), .we(prod_we), .waddr(prod_waddr), .wdata(prod_wdata),
    .raddr(idx_r), .rdata(prod_rdata)
  );

  mmp_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(prod_rdata), .divisor(sum_r),
    .stat(div_stat), .quotient(div_q)
  );

  // factor is zero for a feature or category beyond the table
  assign factor = in_range_r ? cat_rdata : 32'd0;

  // one shared multiplier, registered
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL_EX) begin
      mul_r <= 64'(prod_rdata) * 64'(factor);
    end
  end

  assign prod_shift = mul_r[63:31];
  assign prod_step  = (prod_shift > 33'(Q_ONE)) ? Q_ONE : prod_shift[31:0];
  assign exp_sum    = 13'(exp_r) + 13'(s_r);
  assign out_load   = (state_r == ST_DIV_OUT) && (!ov_r || out_ready);

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    started_nxt  = started_r;
    exp_nxt      = exp_r;
    max_nxt      = max_r;
    s_nxt        = s_r;
    sum_nxt      = sum_r;
    cat_addr_nxt = cat_addr_r;
    in_range_nxt = in_range_r;
    last_nxt     = last_r;
    prod_we      = 1'b0;
    prod_waddr   = idx_r;
    prod_wdata   = prod_rdata;
    div_start    = 1'b0;
    ov_nxt       = ov_r && !out_ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && op_t'(in_operation) == OP_SAMPLE) begin
          // address of cluster 0 for this feature and category
          cat_addr_nxt = CAW'(int'(in_feature_index) * MAX_CLUSTERS * MAX_CATEGORIES
                              + int'(in_category));
          in_range_nxt = smp_ok;
          last_nxt     = in_last_feature;
          idx_nxt      = '0;
          max_nxt      = '0;
          if (!started_r) begin
            started_nxt = 1'b1;
            exp_nxt     = '0;
            state_nxt   = ST_LOAD_RD;
          end else begin
            state_nxt = ST_MUL_RD;
          end
        end
      end
      // copy every prior into the product memory
      ST_LOAD_RD: state_nxt = ST_LOAD_WR;
      ST_LOAD_WR: begin
        prod_we    = 1'b1;
        prod_wdata = prior_rdata;
        if (idx_r == IDX_TOP) begin
          idx_nxt   = '0;
          state_nxt = ST_MUL_RD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_LOAD_RD;
        end
      end
      // product step per cluster in use
      ST_MUL_RD: state_nxt = ST_MUL_EX;
      ST_MUL_EX: state_nxt = ST_MUL_WR;
      ST_MUL_WR: begin
        prod_we    = 1'b1;
        prod_wdata = prod_step;
        if (prod_step > max_r) begin
          max_nxt = prod_step;
        end
        cat_addr_nxt = cat_addr_r + CAT_STEP;
        if (idx_r == n_m1) begin
          idx_nxt = '0;
          s_nxt   = '0;
          if (max_nxt != 32'd0) begin
            state_nxt = ST_NORM_FIND;
          end else if (last_r) begin
            sum_nxt   = '0;
            state_nxt = ST_SUM_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_MUL_RD;
        end
      end
      // shift search, one bit a cycle
      ST_NORM_FIND: begin
        if (max_r[31:30] == 2'b00) begin
          max_nxt = {max_r[30:0], 1'b0};
          s_nxt   = s_r + 5'd1;
        end else begin
          exp_nxt = (exp_sum > 13'(EXP_MAX)) ? EXP_MAX : exp_sum[11:0];
          if (s_r != 5'd0) begin
            state_nxt = ST_NORM_RD;
          end else if (last_r) begin
            sum_nxt   = '0;
            state_nxt = ST_SUM_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_NORM_RD: state_nxt = ST_NORM_WR;
      ST_NORM_WR: begin
        prod_we    = 1'b1;
        prod_wdata = prod_rdata << s_r;
        if (idx_r == n_m1) begin
          idx_nxt = '0;
          if (last_r) begin
            sum_nxt   = '0;
            state_nxt = ST_SUM_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_NORM_RD;
        end
      end
      // sum of products in use
      ST_SUM_RD: state_nxt = ST_SUM_ACC;
      ST_SUM_ACC: begin
        sum_nxt = sum_r + SUM_W'(prod_rdata);
        if (idx_r == n_m1) begin
          idx_nxt   = '0;
          state_nxt = ST_DIV_RD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_SUM_RD;
        end
      end
      // one division per cluster
      ST_DIV_RD: state_nxt = ST_DIV_START;
      ST_DIV_START: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_nxt = ST_DIV_OUT;
        end
      end
      ST_DIV_OUT: begin
        if (out_load) begin
          ov_nxt = 1'b1;
          if (idx_r == n_m1) begin
            started_nxt = 1'b0;
            state_nxt   = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_DIV_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      idx_r     <= '0;
      started_r <= 1'b0;
      exp_r     <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      started_r <= started_nxt;
      exp_r     <= exp_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    max_r      <= max_nxt;
    s_r        <= s_nxt;
    sum_r      <= sum_nxt;
    cat_addr_r <= cat_addr_nxt;
    in_range_r <= in_range_nxt;
    last_r     <= last_nxt;
    if (out_load) begin
      oid_r   <= 4'(idx_r);
      // zero sum gives zero posteriors
      opost_r <= (sum_r == '0) ? 32'd0 : div_q;
      olast_r <= (idx_r == n_m1);
    end
  end

  assign out_valid        = ov_r;
  assign out_cluster_id   = oid_r;
  assign out_posterior    = opost_r;
  assign out_last_cluster = olast_r;

  // divider runs only while the sequencer waits on it
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == ST_DIV_WAIT)
    else $error("divider busy outside division wait");

  // product step never exceeds one
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (prod_we && state_r == ST_MUL_WR) |-> prod_wdata <= Q_ONE)
    else $error("product step above one");

  // posterior never exceeds one
  a_post_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> opost_r <= Q_ONE)
    else $error("posterior above one");

  // the sequencer leaves idle only on an accepted sample request
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && state_nxt != ST_IDLE) |->
      (in_acc && op_t'(in_operation) == OP_SAMPLE))
    else $error("sequencer started without a sample request");
endmodule
`default_nettype wire

/* test/multinomial_mixture_posterior_test.sv */
// self-checking bench for the mixture of multinomials posterior block
// depends on mmp_pkg and the multinomial_mixture_posterior rtl
`default_nettype none
module multinomial_mixture_posterior_test import mmp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLUSTERS    = 16;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 200;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_operation;
  logic [3:0]  in_cluster_index;
  logic [5:0]  in_feature_index;
  logic [3:0]  in_category;
  logic [31:0] in_table_value;
  logic        in_last_feature;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_cluster_id;
  logic [31:0] out_posterior;
  logic        out_last_cluster;

  multinomial_mixture_posterior dut (.*);

  // one posterior as it should leave the block
  typedef struct packed {
    logic [3:0]  id;
    logic [31:0] post;
    logic        last;
  } posterior_t;

  // one row of the directed part, typed rows carry the posterior of every cluster
  typedef struct packed {
    op_t         op;
    logic [3:0]  ci;
    logic [5:0]  fi;
    logic [3:0]  cat;
    logic [31:0] val;
    logic        last;
    logic        typed;
    logic [31:0] want;
  } row_t;

  posterior_t  pending_posteriors[$];
  int          errors;
  int          cycles;
  int          send_idle;
  int          recv_idle;
  int          requests;

  // shadow state of the block
  logic [4:0]  count_reg;
  logic [31:0] prior_mem[CLUSTERS];
  logic [31:0] category_mem[16384];
  bit          category_known[16384];
  logic [31:0] product[CLUSTERS];
  bit          in_sample;
  logic [31:0] step_post[CLUSTERS];
  int          step_n;

  // clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("multinomial_mixture_posterior_test: errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // result side: random stalls and in-order compare against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_posteriors.size() == 0) begin
          report_mismatch("posterior with nothing pending", out_posterior, 32'h0);
        end else begin
          posterior_t w;
          w = pending_posteriors.pop_front();
          if (out_cluster_id !== w.id)
            report_mismatch("cluster_id", 32'(out_cluster_id), 32'(w.id));
          if (out_posterior !== w.post) report_mismatch("posterior", out_posterior, w.post);
          if (out_last_cluster !== w.last)
            report_mismatch("last_cluster", 32'(out_last_cluster), 32'(w.last));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic int clusters_in_use();
    if (count_reg == 0) return 1;
    if (count_reg > CLUSTERS) return CLUSTERS;
    return int'(count_reg);
  endfunction

  function automatic logic [31:0] sat_one(logic [63:0] v);
    return (v > {32'h0, Q_ONE}) ? Q_ONE : v[31:0];
  endfunction

  // advance the shadow state by one request, posteriors land in step_post
  task automatic posterior_step(input op_t op, input logic [3:0] ci, input logic [5:0] fi,
                                input logic [3:0] cat, input logic [31:0] val,
                                input logic last);
    logic [31:0] v;
    logic [31:0] peak;
    logic [63:0] sum;
    int          n;
    v = sat_one({32'h0, val});
    step_n = 0;
    case (op)
      OP_WRITE_PRIOR: begin
        prior_mem[ci] = v;
      end
      OP_WRITE_CATEGORY: begin
        category_mem[{fi, ci, cat}] = v;
        category_known[{fi, ci, cat}] = 1'b1;
      end
      OP_SAMPLE: begin
        // first feature reloads every product from its prior
        if (!in_sample) begin
          for (int c = 0; c < CLUSTERS; c++) product[c] = prior_mem[c];
          in_sample = 1'b1;
        end
        n = clusters_in_use();
        peak = 32'h0;
        for (int c = 0; c < n; c++) begin
          product[c] = sat_one((64'(product[c]) * 64'(category_mem[{fi, 4'(c), cat}])) >> 31);
          if (product[c] > peak) peak = product[c];
        end
        // shared renormalization keeps the largest product at or above one half
        if (peak != 0) begin
          while (peak < 32'h4000_0000) begin
            peak = peak << 1;
            for (int c = 0; c < n; c++) product[c] = product[c] << 1;
          end
        end
        if (last) begin
          sum = 64'h0;
          for (int c = 0; c < n; c++) sum += 64'(product[c]);
          for (int c = 0; c < n; c++)
            step_post[c] = (sum == 0) ? 32'h0 : 32'((64'(product[c]) << 31) / sum);
          step_n = n;
          in_sample = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  // drive one request, wait for acceptance, then queue what it should produce
  task automatic send_request(input op_t op, input logic [3:0] ci, input logic [5:0] fi,
                              input logic [3:0] cat, input logic [31:0] val,
                              input logic last, input bit typed, input logic [31:0] want);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_cluster_index <= ci;
    in_feature_index <= fi;
    in_category      <= cat;
    in_table_value   <= val;
    in_last_feature  <= last;
    do @(posedge clk); while (!in_ready);
    requests++;
    posterior_step(op, ci, fi, cat, val, last);
    for (int c = 0; c < step_n; c++)
      pending_posteriors.push_back({4'(c), typed ? want : step_post[c], c == step_n - 1});
  endtask

  task automatic quiet_sender();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold the requests back until every posterior has come, then let the sequencer settle
  task automatic drain();
    quiet_sender();
    while (pending_posteriors.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cluster_count(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_CLUSTER_COUNT);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    count_reg = value[4:0];
  endtask

  function automatic logic [31:0] random_probability();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return Q_ONE;
      2: return $urandom();
      3: return $urandom_range(255);
      4: return $urandom_range(32'h8000_0000);
      default: return 32'h8000_0000 >> $urandom_range(31);
    endcase
  endfunction

  // one sample feature, writing any table entry it would read that is still unknown
  task automatic send_feature(input logic [5:0] fi, input logic [3:0] cat, input logic last);
    for (int c = 0; c < clusters_in_use(); c++)
      if (!category_known[{fi, 4'(c), cat}])
        send_request(OP_WRITE_CATEGORY, 4'(c), fi, cat, random_probability(), 1'b0,
                     1'b0, 32'h0);
    send_request(OP_SAMPLE, 4'($urandom()), fi, cat, $urandom(), last, 1'b0, 32'h0);
  endtask

  // random traffic: mostly whole samples, some stray writes and ignored requests
  task automatic random_traffic(input int items);
    int first;
    int len;
    logic [5:0] fi;
    logic [3:0] cat;
    first = requests;
    while (requests - first < items) begin
      case ($urandom_range(9))
        0: begin
          send_request(OP_NONE, 4'($urandom()), 6'($urandom()), 4'($urandom()), $urandom(),
                       1'($urandom()), 1'b0, 32'h0);
        end
        1: begin
          send_request(OP_WRITE_PRIOR, 4'($urandom()), 6'($urandom()), 4'($urandom()),
                       random_probability(), 1'($urandom()), 1'b0, 32'h0);
        end
        2: begin
          send_request(OP_WRITE_CATEGORY, 4'($urandom()), 6'($urandom()), 4'($urandom()),
                       random_probability(), 1'($urandom()), 1'b0, 32'h0);
        end
        default: begin
          // features and categories drawn from a narrow pool so the table fills and gets reused
          len = $urandom_range(1, 6);
          for (int k = 0; k < len; k++) begin
            fi  = ($urandom_range(3) == 0) ? 6'($urandom()) : 6'($urandom_range(7));
            cat = ($urandom_range(3) == 0) ? 4'($urandom()) : 4'($urandom_range(3));
            send_feature(fi, cat, k == len - 1);
            if ($urandom_range(7) == 0 && k != len - 1)
              send_request(OP_WRITE_PRIOR, 4'($urandom()), 6'd0, 4'd0, random_probability(),
                           1'b0, 1'b0, 32'h0);
          end
        end
      endcase
    end
  endtask

  row_t directed[14];
  logic [31:0] count_plan[6];

  initial begin
    errors    = 0;
    cycles    = 0;
    requests  = 0;
    send_idle = 38;
    recv_idle = 58;
    in_sample = 1'b0;
    count_reg = 5'd16;
    for (int i = 0; i < 16384; i++) begin
      category_mem[i]   = 32'h0;
      category_known[i] = 1'b0;
    end
    for (int c = 0; c < CLUSTERS; c++) begin
      prior_mem[c] = 32'h0;
      product[c]   = 32'h0;
    end
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = 3'h0;
    pwdata           = 32'h0;
    in_valid         = 1'b0;
    in_operation     = OP_NONE;
    in_cluster_index = 4'h0;
    in_feature_index = 6'h0;
    in_category      = 4'h0;
    in_table_value   = 32'h0;
    in_last_feature  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // setup: equal priors, a one column, a saturated column and a zero column
    for (int c = 0; c < CLUSTERS; c++) begin
      send_request(OP_WRITE_PRIOR, 4'(c), 6'd0, 4'd0, Q_ONE, 1'b0, 1'b0, 32'h0);
      send_request(OP_WRITE_CATEGORY, 4'(c), 6'd0, 4'd0, Q_ONE, 1'b0, 1'b0, 32'h0);
      send_request(OP_WRITE_CATEGORY, 4'(c), 6'd63, 4'd15, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0);
      send_request(OP_WRITE_CATEGORY, 4'(c), 6'd1, 4'd1, 32'h0, 1'b0, 1'b0, 32'h0);
    end

    directed = '{
      // equal products over sixteen clusters give one sixteenth each
      '{OP_SAMPLE,         4'd0,  6'd0,  4'd0,  32'h0,         1'b1, 1'b1, 32'h0800_0000},
      // saturated entries act as one
      '{OP_SAMPLE,         4'd9,  6'd63, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0800_0000},
      // zero sum gives zero posteriors
      '{OP_SAMPLE,         4'd0,  6'd1,  4'd1,  32'h0,         1'b1, 1'b1, 32'h0},
      // ignored operation
      '{OP_NONE,           4'd15, 6'd63, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0},
      '{OP_WRITE_PRIOR,    4'd15, 6'd0,  4'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{OP_WRITE_PRIOR,    4'd0,  6'd0,  4'd0,  32'h0000_0001, 1'b0, 1'b0, 32'h0},
      '{OP_WRITE_CATEGORY, 4'd7,  6'd0,  4'd0,  32'h0000_0003, 1'b0, 1'b0, 32'h0},
      // multi-feature sample with a tiny prior and a tiny table entry
      '{OP_SAMPLE,         4'd0,  6'd0,  4'd0,  32'h0,         1'b0, 1'b0, 32'h0},
      '{OP_SAMPLE,         4'd0,  6'd63, 4'd15, 32'h0,         1'b0, 1'b0, 32'h0},
      '{OP_SAMPLE,         4'd0,  6'd0,  4'd0,  32'h0,         1'b1, 1'b0, 32'h0},
      // table write in the middle of a sample leaves the products alone
      '{OP_SAMPLE,         4'd0,  6'd0,  4'd0,  32'h0,         1'b0, 1'b0, 32'h0},
      '{OP_WRITE_PRIOR,    4'd3,  6'd0,  4'd0,  32'h4000_0000, 1'b0, 1'b0, 32'h0},
      '{OP_WRITE_CATEGORY, 4'd2,  6'd0,  4'd0,  32'h1234_5678, 1'b0, 1'b0, 32'h0},
      '{OP_SAMPLE,         4'd0,  6'd0,  4'd0,  32'h0,         1'b1, 1'b0, 32'h0}
    };
    foreach (directed[i])
      send_request(directed[i].op, directed[i].ci, directed[i].fi, directed[i].cat,
                   directed[i].val, directed[i].last, directed[i].typed, directed[i].want);

    // counts include the extremes, zero acting as one and an oversize value
    count_plan = '{32'd1, 32'd0, 32'd31, 32'd16, 32'd5, 32'($urandom_range(1, 16))};
    foreach (count_plan[p]) begin
      drain();
      write_cluster_count(count_plan[p]);
      if (p == 2) begin
        send_idle = 58;
        recv_idle = 38;
      end else if (p == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      random_traffic(50);
    end

    quiet_sender();
    while (pending_posteriors.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending_posteriors.size() == 0) begin
      $display("multinomial_mixture_posterior_test: clean");
    end else begin
      $display("multinomial_mixture_posterior_test: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/mmp_pkg.sv
rtl/mmp_ram.sv
rtl/mmp_divider.sv
rtl/multinomial_mixture_posterior.sv
test/multinomial_mixture_posterior_test.sv
